// ===== rtl/lpr_pkg.sv =====
// Shared types, constants and helpers of the line pixel rasteriser.
`timescale 1ns / 1ps
package lpr_pkg;

	localparam int COORD_BITS  = 12;
	localparam int COLOR_BITS  = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;

	// Kind of an input item, carried in tuser.
	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	localparam coord_t WIDTH_RESET  = coord_t'(320);
	localparam coord_t HEIGHT_RESET = coord_t'(240);

	// One classified command handed from the front to the back.
	typedef struct packed {
		cmd_t   cmd;
		logic   major_is_x;
		coord_t major_origin;
		coord_t minor_origin;
		coord_t major_span;
		coord_t minor_span;
		logic   minor_descends;
		color_t color;
	} q_entry_t;

	// Status of the back end, watched at the top level.
	typedef struct packed {
		logic active;
		logic pop;
		logic emit;
		logic emit_last;
	} back_status_t;

	// Clamp a coordinate to size-1; a size of zero acts as a size of one.
	function automatic coord_t clamp_coord(input coord_t v, input coord_t size);
		coord_t limit;
		limit = (size == '0) ? '0 : size - coord_t'(1);
		return (v > limit) ? limit : v;
	endfunction

endpackage

// ===== rtl/lpr_front.sv =====
// Front end: accepts items, clamps endpoints and classifies the line.
`timescale 1ns / 1ps
module lpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  lpr_pkg::coord_t   cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       in_data,
	input  logic              in_user,
	output logic              push,
	output lpr_pkg::q_entry_t entry,
	input  logic              q_full
);

	lpr_pkg::coord_t width_q, height_q;

	logic             valid_s1;
	lpr_pkg::cmd_t    cmd_s1;
	lpr_pkg::coord_t  x0_s1, y0_s1, x1_s1, y1_s1;
	lpr_pkg::color_t  color_s1;

	logic             take;
	lpr_pkg::coord_t  dx, dy;
	logic             x_rev, y_rev, y_fall, x_fall, major_x;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lpr_pkg::WIDTH_RESET;
			height_q <= lpr_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (lpr_pkg::reg_idx_t'(cfg_addr))
				lpr_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
				lpr_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The stage takes an item when it is empty or hands its item on.
	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Clamped endpoints; payload needs no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1   <= lpr_pkg::cmd_t'(in_user);
			x0_s1    <= lpr_pkg::clamp_coord(in_data[11:0], width_q);
			y0_s1    <= lpr_pkg::clamp_coord(in_data[23:12], height_q);
			x1_s1    <= lpr_pkg::clamp_coord(in_data[35:24], width_q);
			y1_s1    <= lpr_pkg::clamp_coord(in_data[47:36], height_q);
			color_s1 <= in_data[63:48];
		end
	end

	// Extents and directions, all side by side.
	always_comb begin
		x_rev   = x0_s1 > x1_s1;
		y_rev   = y0_s1 > y1_s1;
		x_fall  = x1_s1 > x0_s1;
		y_fall  = y1_s1 > y0_s1;
		dx      = x_rev ? x0_s1 - x1_s1 : x1_s1 - x0_s1;
		dy      = y_rev ? y0_s1 - y1_s1 : y1_s1 - y0_s1;
		major_x = !(dx < dy);
	end

	// Walk the major axis upward; the minor origin follows the swap.
	always_comb begin
		entry.cmd        = cmd_s1;
		entry.major_is_x = major_x;
		entry.color      = color_s1;
		if (major_x) begin
			entry.major_origin   = x_rev ? x1_s1 : x0_s1;
			entry.minor_origin   = x_rev ? y1_s1 : y0_s1;
			entry.major_span     = dx;
			entry.minor_span     = dy;
			entry.minor_descends = x_rev ? y_fall : y_rev;
		end else begin
			entry.major_origin   = y_rev ? y1_s1 : y0_s1;
			entry.minor_origin   = y_rev ? x1_s1 : x0_s1;
			entry.major_span     = dy;
			entry.minor_span     = dx;
			entry.minor_descends = y_rev ? x_fall : x_rev;
		end
	end

endmodule

// ===== rtl/lpr_queue.sv =====
// Short queue of classified commands between the front and the back.
`timescale 1ns / 1ps
module lpr_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lpr_pkg::q_entry_t            wr_entry,
	output logic                         full,
	input  logic                         pop,
	output lpr_pkg::q_entry_t            rd_entry,
	output logic                         empty,
	output logic [lpr_pkg::QCNT_BITS-1:0] count
);

	lpr_pkg::q_entry_t                slot_q [lpr_pkg::QUEUE_DEPTH];
	logic [lpr_pkg::QPTR_BITS-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lpr_pkg::QCNT_BITS-1:0]    count_q;

	assign full     = count_q == lpr_pkg::QCNT_BITS'(lpr_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign count    = count_q;
	assign rd_entry = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== rtl/lpr_back.sv =====
// Back end: holds the line and steps it one pixel per advance command.
`timescale 1ns / 1ps
module lpr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpr_pkg::q_entry_t     entry,
	input  logic                  empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [39:0]           out_data,
	output logic                  out_last,
	output lpr_pkg::back_status_t status
);

	logic            active_q, major_is_x_q, descends_q;
	lpr_pkg::coord_t major_pos_q, minor_pos_q, major_span_q, minor_span_q;
	lpr_pkg::coord_t step_q, rem_q;
	lpr_pkg::color_t color_q;

	logic            out_valid_q, out_last_q;
	logic [39:0]     out_data_q;

	logic            out_free, is_load, emit, last;
	logic [lpr_pkg::COORD_BITS:0] rem_sum;
	logic            carry;

	assign out_free = !out_valid_q || out_ready;
	assign is_load  = entry.cmd == lpr_pkg::CMD_LOAD;
	assign pop      = !empty && (is_load || !active_q || out_free);
	assign emit     = pop && !is_load && active_q;
	assign last     = step_q >= major_span_q;

	// Remainder of minor_span*step/major_span, kept incrementally.
	assign rem_sum = {1'b0, rem_q} + {1'b0, minor_span_q};
	assign carry   = rem_sum >= {1'b0, major_span_q};

	// Line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop && is_load) begin
			active_q <= 1'b1;
		end else if (emit && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_load) begin
			major_is_x_q <= entry.major_is_x;
			descends_q   <= entry.minor_descends;
			major_pos_q  <= entry.major_origin;
			minor_pos_q  <= entry.minor_origin;
			major_span_q <= entry.major_span;
			minor_span_q <= entry.minor_span;
			color_q      <= entry.color;
			step_q       <= '0;
			rem_q        <= '0;
		end else if (emit && !last) begin
			step_q      <= step_q + 1'b1;
			major_pos_q <= major_pos_q + 1'b1;
			if (carry) begin
				rem_q       <= rem_sum[lpr_pkg::COORD_BITS-1:0] - major_span_q;
				minor_pos_q <= descends_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
			end else begin
				rem_q <= rem_sum[lpr_pkg::COORD_BITS-1:0];
			end
		end
	end

	// Output register parts the back from the downstream sink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q[11:0]  <= major_is_x_q ? major_pos_q : minor_pos_q;
			out_data_q[23:12] <= major_is_x_q ? minor_pos_q : major_pos_q;
			out_data_q[39:24] <= color_q;
			out_last_q        <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	assign status.active    = active_q;
	assign status.pop       = pop;
	assign status.emit      = emit;
	assign status.emit_last = emit && last;

endmodule

// ===== rtl/line_pixel_rasterizer.sv =====
// Top level of the line pixel rasteriser: front, command queue and back.
//
//  Channel  Signals                           Item
//  s_axis   tvalid tready tdata[63:0] tuser   load or advance command
//  m_axis   tvalid tready tdata[39:0] tlast   one pixel of the line
//  cfg      cfg_we cfg_addr cfg_wdata[11:0]   screen width / height
//
// A load emits nothing; an advance on an active line gives one pixel, one
// per clock unless the output stalls, set by the incremental remainder
// update. An item passes the front stage, queue and output register before
// its pixel appears. Reset clears control state only. The two-entry queue
// lets the front keep taking items while the output is stalled.
`timescale 1ns / 1ps
module line_pixel_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], line_color[63:48]
	input  logic [63:0] s_axis_tdata,
	// cmd[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_color[39:24]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	logic                             push, q_full, q_empty, pop;
	lpr_pkg::q_entry_t                wr_entry, rd_entry;
	logic [lpr_pkg::QCNT_BITS-1:0]    q_count;
	lpr_pkg::back_status_t            status;

	lpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.push     (push),
		.entry    (wr_entry),
		.q_full   (q_full)
	);

	lpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.full    (q_full),
		.pop     (pop),
		.rd_entry(rd_entry),
		.empty   (q_empty),
		.count   (q_count)
	);

	lpr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (rd_entry),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast),
		.status   (status)
	);

	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= lpr_pkg::QCNT_BITS'(lpr_pkg::QUEUE_DEPTH))
		else $error("command queue overfilled");

	// The back never takes a command from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> (q_count != '0))
		else $error("pop from empty command queue");

	// Emitting the final pixel closes the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.emit_last |=> (!status.active || $past(status.pop && !status.emit)))
		else $error("line still active after its last pixel");

	// A pixel is produced only while a line is active.
	assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |-> status.active)
		else $error("pixel emitted with no active line");

	// The input side stalls only when the front stage cannot hand on.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_full)
		else $error("input stalled while the queue has room");

endmodule

// ===== dv/line_pixel_rasterizer_checker.sv =====
// Checker for the line pixel rasteriser: predicts every pixel and compares the output stream.
`timescale 1ns / 1ps
module line_pixel_rasterizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], line_color[63:48]
	input  logic [63:0] s_axis_tdata,
	// cmd[0]
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_x[11:0], pixel_y[23:12], pixel_color[39:24]
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          pixels_owed
);

	typedef struct packed {
		lpr_pkg::color_t color;
		lpr_pkg::coord_t y;
		lpr_pkg::coord_t x;
		logic            last;
	} pixel_t;

	// Pixels predicted but not yet seen on the output, oldest first.
	pixel_t pixels_due[$];
	int     errs;

	// Shadow of the screen size registers.
	lpr_pkg::coord_t screen_w;
	lpr_pkg::coord_t screen_h;

	// Shadow of the line walker.
	logic            tracing;
	logic            x_major;
	lpr_pkg::coord_t major_base;
	lpr_pkg::coord_t minor_base;
	lpr_pkg::coord_t major_len;
	lpr_pkg::coord_t minor_len;
	logic            minor_down;
	lpr_pkg::coord_t step;
	lpr_pkg::color_t ink;

	// Limit a coordinate to the visible range; a zero size behaves as a size of one.
	function automatic lpr_pkg::coord_t fit_coord(input lpr_pkg::coord_t v,
			input lpr_pkg::coord_t size);
		lpr_pkg::coord_t top;
		top = (size == '0) ? '0 : lpr_pkg::coord_t'(size - 1'b1);
		return (v > top) ? top : v;
	endfunction

	// Apply one accepted item to the shadow walker, queueing the pixel it produces.
	task automatic plot_item(input lpr_pkg::cmd_t kind, input logic [63:0] d);
		lpr_pkg::coord_t x0, y0, x1, y1, dx, dy;
		lpr_pkg::coord_t a0, a1, b0, b1, swap;
		lpr_pkg::coord_t major, minor, offset;
		int unsigned     prod;
		pixel_t          px;
		if (kind == lpr_pkg::CMD_LOAD) begin
			x0 = fit_coord(d[11:0], screen_w);
			y0 = fit_coord(d[23:12], screen_h);
			x1 = fit_coord(d[35:24], screen_w);
			y1 = fit_coord(d[47:36], screen_h);
			dx = (x0 > x1) ? lpr_pkg::coord_t'(x0 - x1) : lpr_pkg::coord_t'(x1 - x0);
			dy = (y0 > y1) ? lpr_pkg::coord_t'(y0 - y1) : lpr_pkg::coord_t'(y1 - y0);
			// Ties go to the x axis.
			x_major = !(dx < dy);
			if (x_major) begin
				a0 = x0; a1 = x1; b0 = y0; b1 = y1;
			end else begin
				a0 = y0; a1 = y1; b0 = x0; b1 = x1;
			end
			// Always walk the major axis upward.
			if (a0 > a1) begin
				swap = a0; a0 = a1; a1 = swap;
				swap = b0; b0 = b1; b1 = swap;
			end
			major_base = a0;
			minor_base = b0;
			major_len  = a1 - a0;
			minor_down = b0 > b1;
			minor_len  = minor_down ? lpr_pkg::coord_t'(b0 - b1)
				: lpr_pkg::coord_t'(b1 - b0);
			step       = '0;
			ink        = d[63:48];
			tracing    = 1'b1;
		end else if (tracing) begin
			major = major_base + step;
			prod  = minor_len * step;
			offset = (major_len == '0) ? '0 : lpr_pkg::coord_t'(prod / major_len);
			minor = minor_down ? lpr_pkg::coord_t'(minor_base - offset)
				: lpr_pkg::coord_t'(minor_base + offset);
			px.last  = (step >= major_len);
			px.x     = x_major ? major : minor;
			px.y     = x_major ? minor : major;
			px.color = ink;
			pixels_due.push_back(px);
			if (px.last) begin
				tracing = 1'b0;
			end else begin
				step = step + 1'b1;
			end
		end
	endtask

	// Watch the three channels at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			pixels_due.delete();
			errs       = 0;
			screen_w   = lpr_pkg::WIDTH_RESET;
			screen_h   = lpr_pkg::HEIGHT_RESET;
			tracing    = 1'b0;
			x_major    = 1'b0;
			major_base = '0;
			minor_base = '0;
			major_len  = '0;
			minor_len  = '0;
			minor_down = 1'b0;
			step       = '0;
			ink        = '0;
		end else begin
			// Output side first: a pixel seen now always belongs to an older item.
			if (m_axis_tvalid && m_axis_tready) begin
				got.x     = m_axis_tdata[11:0];
				got.y     = m_axis_tdata[23:12];
				got.color = m_axis_tdata[39:24];
				got.last  = m_axis_tlast;
				if (pixels_due.size() == 0) begin
					errs++;
					$display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
						$time, got.x, got.y, got.color, got.last);
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						errs++;
						if (got.x !== want.x)
							$display("%0t: pixel_x expected %0d, got %0d",
								$time, want.x, got.x);
						if (got.y !== want.y)
							$display("%0t: pixel_y expected %0d, got %0d",
								$time, want.y, got.y);
						if (got.color !== want.color)
							$display("%0t: pixel_color expected %h, got %h",
								$time, want.color, got.color);
						if (got.last !== want.last)
							$display("%0t: last_pixel expected %b, got %b",
								$time, want.last, got.last);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				plot_item(lpr_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
			if (cfg_we) begin
				case (lpr_pkg::reg_idx_t'(cfg_addr))
					lpr_pkg::REG_SCREEN_WIDTH: begin
						screen_w = cfg_wdata;
					end
					lpr_pkg::REG_SCREEN_HEIGHT: begin
						screen_h = cfg_wdata;
					end
					default: begin
					end
				endcase
			end
		end
		mismatches  <= errs;
		pixels_owed <= pixels_due.size();
	end

endmodule

// ===== dv/line_pixel_rasterizer_tb.sv =====
// Testbench top for the line pixel rasteriser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module line_pixel_rasterizer_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic [11:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          mismatches;
	int          pixels_owed;

	// Current screen size, kept by the stimulus to aim endpoints near the edges.
	int          cur_w;
	int          cur_h;
	// Set for stretches where neither side idles.
	logic        calm;
	// Long output hold-offs asked for, and those already served.
	int          hold_asks;
	int          holds_done;

	line_pixel_rasterizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	line_pixel_rasterizer_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.pixels_owed   (pixels_owed)
	);

	// 12 ns clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#5000000;
		$display("line_pixel_rasterizer_tb failed");
		$finish;
	end

	// Random idle length: mostly none or short, now and then long.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 30);
	endfunction

	// Output side: random back-pressure, plus a long hold-off when one is asked for.
	initial begin
		int r;
		m_axis_tready = 1'b0;
		holds_done    = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				holds_done++;
				m_axis_tready <= 1'b1;
			end else begin
				r = idle_cycles();
				if (r == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					repeat (r) @(negedge clk);
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	function automatic int clip_coord(input int v);
		return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
	endfunction

	// Offer one item after a random gap and wait until it is taken.
	task automatic push_item(input lpr_pkg::cmd_t kind, input logic [63:0] d);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic load_line(input int x0, input int y0, input int x1, input int y1,
			input int color);
		push_item(lpr_pkg::CMD_LOAD,
			{color[15:0], y1[11:0], x1[11:0], y0[11:0], x0[11:0]});
	endtask

	// Advances carry random payload, which the block must ignore.
	task automatic advance(input int n);
		repeat (n) push_item(lpr_pkg::CMD_ADVANCE, {$urandom(), $urandom()});
	endtask

	// Stop offering items and wait until every predicted pixel has come out.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	// Change the screen size while the block is idle.
	task automatic set_screen(input int w, input int h);
		settle();
		cfg_we    <= 1'b1;
		cfg_addr  <= lpr_pkg::REG_SCREEN_WIDTH;
		cfg_wdata <= lpr_pkg::coord_t'(w);
		@(negedge clk);
		cfg_addr  <= lpr_pkg::REG_SCREEN_HEIGHT;
		cfg_wdata <= lpr_pkg::coord_t'(h);
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	// Mostly whole lines near the visible area, mixed with wild loads,
	// lines cut short by a new load and stray advances.
	task automatic random_lines(input int n);
		int sent, r, reach, len, dx, dy;
		int x0, y0, x1, y1;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				advance(1);
			end else if (r < 22) begin
				load_line($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 65535));
				len = $urandom_range(0, 40);
				advance(len);
				sent += len + 1;
			end else begin
				reach = ($urandom_range(0, 99) < 4) ? 200 : 12;
				x0 = $urandom_range(0, clip_coord(cur_w + 4));
				y0 = $urandom_range(0, clip_coord(cur_h + 4));
				x1 = clip_coord(x0 + $urandom_range(0, 2 * reach) - reach);
				y1 = clip_coord(y0 + $urandom_range(0, 2 * reach) - reach);
				dx = (x1 > x0) ? x1 - x0 : x0 - x1;
				dy = (y1 > y0) ? y1 - y0 : y0 - y1;
				len = ((dx > dy) ? dx : dy) + 1;
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(0, len);
				load_line(x0, y0, x1, y1, $urandom_range(0, 65535));
				advance(len);
				sent += len + 1;
			end
		end
	endtask

	// Reset, directed lines, then random phases over several screen sizes.
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = lpr_pkg::REG_SCREEN_WIDTH;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = lpr_pkg::CMD_LOAD;
		calm          = 1'b0;
		hold_asks     = 0;
		cur_w         = 320;
		cur_h         = 240;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Advance with no line loaded.
		advance(1);
		// Equal endpoints at the origin, then an advance after the line has ended.
		load_line(0, 0, 0, 0, 16'h0000);
		advance(2);
		// Endpoints far outside the screen clamp to the bottom-right corner.
		load_line(4095, 4095, 4095, 4095, 16'hFFFF);
		advance(1);
		// Endpoint exactly at the width, on a line given right to left.
		load_line(320, 239, 316, 237, 16'hA5C3);
		advance(4);
		// Steep line with the column running downward.
		load_line(2, 7, 4, 3, 16'h5A3C);
		advance(5);
		// Equal extents go to x; a new load replaces the line midway.
		load_line(5, 5, 8, 2, 16'h0F0F);
		advance(2);
		load_line(7, 1, 7, 1, 16'hF0F0);
		advance(1);

		set_screen(4095, 4095);
		calm = 1'b1;
		random_lines(60);
		calm = 1'b0;
		random_lines(90);

		set_screen(1, 1);
		random_lines(40);

		// A zero size behaves as one pixel wide or tall.
		set_screen(0, 0);
		random_lines(40);

		set_screen(640, 480);
		hold_asks++;
		random_lines(150);

		set_screen($urandom_range(1, 4095), $urandom_range(1, 4095));
		random_lines(150);

		set_screen(12, 4095);
		hold_asks++;
		random_lines(150);

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pixels_owed == 0)
			$display("line_pixel_rasterizer_tb passed");
		else
			$display("line_pixel_rasterizer_tb failed");
		$finish;
	end

endmodule
